// File: rtl/asp_pkg.sv
// ============================================================================
// asp_pkg
// Shared types and constants for the separation PID controller.
// ============================================================================
`default_nettype none

package asp_pkg;

    localparam int GAIN_WIDTH = 24;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    typedef enum logic [2:0] {
        REG_SETPOINT    = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_SEP_LIMIT   = 3'd4,
        REG_MEAS_UPPER  = 3'd5,
        REG_MEAS_LOWER  = 3'd6
    } asp_reg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } asp_mult_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/asp_gain_mult.sv
// ============================================================================
// asp_gain_mult
// Two-stage signed operand by unsigned gain multiplier, split in two halves.
// ============================================================================
`default_nettype none

module asp_gain_mult #(
    parameter int OP_WIDTH = asp_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                            clk,
    input  wire asp_pkg::asp_mult_ctrl_t                         ctrl,
    input  wire logic signed [OP_WIDTH-1:0]                      operand,
    input  wire logic [asp_pkg::GAIN_WIDTH-1:0]                  gain,
    output logic signed [OP_WIDTH+asp_pkg::GAIN_WIDTH-1:0]       product
);

    localparam int G    = asp_pkg::GAIN_WIDTH;
    localparam int LO_W = OP_WIDTH / 2;
    localparam int HI_W = OP_WIDTH - LO_W;
    localparam int P    = OP_WIDTH + G;

    logic [LO_W+G-1:0]          lo_prod_reg;
    logic [LO_W+G-1:0]          lo_prod_next;
    logic signed [HI_W+G:0]     hi_prod_reg;
    logic signed [HI_W+G:0]     hi_prod_next;
    logic signed [P:0]          full_sum;
    logic signed [P-1:0]        product_reg;

    always_comb
    begin
        lo_prod_next = (LO_W+G)'(operand[LO_W-1:0]) * (LO_W+G)'(gain);
        hi_prod_next = (HI_W+G+1)'($signed(operand[OP_WIDTH-1:LO_W]))
                     * (HI_W+G+1)'($signed({1'b0, gain}));
        full_sum = $signed({hi_prod_reg, {LO_W{1'b0}}})
                 + $signed({{(HI_W+1){1'b0}}, lo_prod_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
        if (ctrl.load_b)
        begin
            product_reg <= full_sum[P-1:0];
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// File: rtl/antiwindup_separation_pid.sv
// ============================================================================
// antiwindup_separation_pid
// Positional PID with integral separation and measurement-based anti-windup.
// ============================================================================
// Each measurement beat on the input channel yields one result beat carrying
// the saturated drive value, an integral-in-use flag and a clipping flag.
// Gains, setpoint, separation limit and measurement bounds must be written
// over the APB port only while the block is idle; it does not enforce this.
// Reads return the stored values. The datapath is a five-register
// pipeline: input register, error and integral update, partial products,
// product sums, and the output register. Beats pass through them in order,
// and one beat can be accepted in every cycle unless the receiver stalls.
// The integral and previous error are updated in the second register stage
// with a single saturating add, so beats can follow each other without a gap.
// When the receiver stalls, the output beat holds and earlier stages keep
// filling empty slots; measurement_stall rises only once every stage holds
// a beat. Reset clears the pipeline, the integral and the previous error,
// sets the measurement bounds to the full range and clears the other
// registers.
// ============================================================================
`default_nettype none

module antiwindup_separation_pid #(
    parameter int DATA_WIDTH = asp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = asp_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = asp_pkg::ACC_WIDTH_DEF,
    localparam int PDATA_W   = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB  = (DATA_WIDTH > 32) ? 3 : 2,
    localparam int PADDR_W   = ADDR_LSB + 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [PADDR_W-1:0]           paddr,
    input  wire logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]                prdata,
    output logic                              pready,
    input  wire logic                         measurement_valid,
    output logic                              measurement_stall,
    input  wire logic signed [DATA_WIDTH-1:0] measurement,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0]      drive_value,
    output logic                              integral_used,
    output logic                              drive_clipped
);

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = ACC_WIDTH;
    localparam int G   = asp_pkg::GAIN_WIDTH;
    localparam int SW  = ((AW > DW) ? AW : DW) + 1;
    localparam int PPW = DW + G;
    localparam int PDW = DW + 1 + G;
    localparam int PIW = AW + G;
    localparam int TW  = ((PDW > PIW) ? PDW : PIW) + 2;

    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [SW-1:0] AMAX_S = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN_S = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};
    localparam logic signed [TW-1:0] OMAX_T = {{(TW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [TW-1:0] OMIN_T = {{(TW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // Configuration registers.
    logic signed [DW-1:0] setpoint_reg;
    logic [G-1:0]         gain_p_reg;
    logic [G-1:0]         gain_i_reg;
    logic [G-1:0]         gain_d_reg;
    logic [DW-2:0]        sep_limit_reg;
    logic signed [DW-1:0] meas_upper_reg;
    logic signed [DW-1:0] meas_lower_reg;

    logic [2:0] reg_idx;
    logic       cfg_write;

    assign reg_idx   = paddr[PADDR_W-1:ADDR_LSB];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            sep_limit_reg  <= '0;
            meas_upper_reg <= DMAX;
            meas_lower_reg <= DMIN;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                asp_pkg::REG_SETPOINT:   setpoint_reg   <= pwdata[DW-1:0];
                asp_pkg::REG_GAIN_P:     gain_p_reg     <= pwdata[G-1:0];
                asp_pkg::REG_GAIN_I:     gain_i_reg     <= pwdata[G-1:0];
                asp_pkg::REG_GAIN_D:     gain_d_reg     <= pwdata[G-1:0];
                asp_pkg::REG_SEP_LIMIT:  sep_limit_reg  <= pwdata[DW-2:0];
                asp_pkg::REG_MEAS_UPPER: meas_upper_reg <= pwdata[DW-1:0];
                asp_pkg::REG_MEAS_LOWER: meas_lower_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            asp_pkg::REG_SETPOINT:   prdata = {{(PDATA_W-DW){1'b0}}, setpoint_reg};
            asp_pkg::REG_GAIN_P:     prdata = {{(PDATA_W-G){1'b0}}, gain_p_reg};
            asp_pkg::REG_GAIN_I:     prdata = {{(PDATA_W-G){1'b0}}, gain_i_reg};
            asp_pkg::REG_GAIN_D:     prdata = {{(PDATA_W-G){1'b0}}, gain_d_reg};
            asp_pkg::REG_SEP_LIMIT:  prdata = {{(PDATA_W-DW+1){1'b0}}, sep_limit_reg};
            asp_pkg::REG_MEAS_UPPER: prdata = {{(PDATA_W-DW){1'b0}}, meas_upper_reg};
            asp_pkg::REG_MEAS_LOWER: prdata = {{(PDATA_W-DW){1'b0}}, meas_lower_reg};
            default:                 prdata = '0;
        endcase
    end

    // Pipeline occupancy and flow.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready0, ready1, ready2, ready3, ready4;
    logic load1;
    asp_pkg::asp_mult_ctrl_t mult_ctrl;

    assign ready4 = !v4_reg || !result_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign ready0 = !v0_reg || ready1;
    assign load1  = v0_reg && ready1;
    assign mult_ctrl.load_a = v1_reg && ready2;
    assign mult_ctrl.load_b = v2_reg && ready3;

    assign measurement_stall = !ready0;
    assign result_valid      = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready0) v0_reg <= measurement_valid;
            if (ready1) v1_reg <= v0_reg;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    // Input register.
    logic signed [DW-1:0] meas_reg;

    always_ff @(posedge clk)
    begin
        if (ready0 && measurement_valid)
        begin
            meas_reg <= measurement;
        end
    end

    // Error, separation test and integral update.
    logic signed [AW-1:0] acc_reg;
    logic signed [DW-1:0] last_err_reg;
    logic signed [DW:0]   err_wide;
    logic                 err_clip;
    logic signed [DW-1:0] err_sat;
    logic [DW-1:0]        err_mag;
    logic                 used;
    logic                 above;
    logic                 below;
    logic                 err_positive;
    logic                 add;
    logic signed [SW-1:0] acc_sum;
    logic signed [AW-1:0] acc_clamped;
    logic signed [AW-1:0] acc_upd;
    logic signed [DW:0]   ediff;

    always_comb
    begin
        err_wide = $signed({setpoint_reg[DW-1], setpoint_reg})
                 - $signed({meas_reg[DW-1], meas_reg});
        err_clip = err_wide[DW] != err_wide[DW-1];
        if (err_clip)
        begin
            err_sat = err_wide[DW] ? DMIN : DMAX;
        end
        else
        begin
            err_sat = err_wide[DW-1:0];
        end
        err_mag = err_sat[DW-1] ? ((~err_sat) + {{(DW-1){1'b0}}, 1'b1}) : err_sat;
        used = err_mag <= {1'b0, sep_limit_reg};
        above = meas_reg > meas_upper_reg;
        below = meas_reg < meas_lower_reg;
        err_positive = !err_sat[DW-1] && (err_sat != '0);
        add = used && !above && (!below || err_positive);

        acc_sum = $signed({{(SW-AW){acc_reg[AW-1]}}, acc_reg})
                + $signed({{(SW-DW){err_sat[DW-1]}}, err_sat});
        if (acc_sum > AMAX_S)
        begin
            acc_clamped = AMAX;
        end
        else if (acc_sum < AMIN_S)
        begin
            acc_clamped = AMIN;
        end
        else
        begin
            acc_clamped = acc_sum[AW-1:0];
        end
        acc_upd = add ? acc_clamped : acc_reg;

        ediff = $signed({err_sat[DW-1], err_sat})
              - $signed({last_err_reg[DW-1], last_err_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            last_err_reg <= '0;
        end
        else if (load1)
        begin
            acc_reg      <= acc_upd;
            last_err_reg <= err_sat;
        end
    end

    logic signed [DW-1:0] s1_err_reg;
    logic signed [DW:0]   s1_ediff_reg;
    logic signed [AW-1:0] s1_iop_reg;
    logic                 s1_used_reg;
    logic                 s1_clip_reg;
    logic                 s2_used_reg;
    logic                 s2_clip_reg;
    logic                 s3_used_reg;
    logic                 s3_clip_reg;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_err_reg   <= err_sat;
            s1_ediff_reg <= ediff;
            s1_iop_reg   <= used ? acc_upd : '0;
            s1_used_reg  <= used;
            s1_clip_reg  <= err_clip;
        end
        if (mult_ctrl.load_a)
        begin
            s2_used_reg <= s1_used_reg;
            s2_clip_reg <= s1_clip_reg;
        end
        if (mult_ctrl.load_b)
        begin
            s3_used_reg <= s2_used_reg;
            s3_clip_reg <= s2_clip_reg;
        end
    end

    // Gain products.
    logic signed [PPW-1:0] prod_p;
    logic signed [PDW-1:0] prod_d;
    logic signed [PIW-1:0] prod_i;

    asp_gain_mult #(.OP_WIDTH(DW)) u_mult_p (
        .clk     (clk),
        .ctrl    (mult_ctrl),
        .operand (s1_err_reg),
        .gain    (gain_p_reg),
        .product (prod_p)
    );

    asp_gain_mult #(.OP_WIDTH(DW + 1)) u_mult_d (
        .clk     (clk),
        .ctrl    (mult_ctrl),
        .operand (s1_ediff_reg),
        .gain    (gain_d_reg),
        .product (prod_d)
    );

    asp_gain_mult #(.OP_WIDTH(AW)) u_mult_i (
        .clk     (clk),
        .ctrl    (mult_ctrl),
        .operand (s1_iop_reg),
        .gain    (gain_i_reg),
        .product (prod_i)
    );

    // Sum, scale and saturate into the output register.
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] scaled;
    logic signed [DW-1:0] drive_next;
    logic                 out_clip;
    logic signed [DW-1:0] drive_value_reg;
    logic                 integral_used_reg;
    logic                 drive_clipped_reg;

    always_comb
    begin
        total = $signed({{(TW-PPW){prod_p[PPW-1]}}, prod_p})
              + $signed({{(TW-PDW){prod_d[PDW-1]}}, prod_d})
              + $signed({{(TW-PIW){prod_i[PIW-1]}}, prod_i});
        scaled = total >>> FRAC_BITS;
        if (scaled > OMAX_T)
        begin
            drive_next = DMAX;
            out_clip   = 1'b1;
        end
        else if (scaled < OMIN_T)
        begin
            drive_next = DMIN;
            out_clip   = 1'b1;
        end
        else
        begin
            drive_next = scaled[DW-1:0];
            out_clip   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && ready4)
        begin
            drive_value_reg   <= drive_next;
            integral_used_reg <= s3_used_reg;
            drive_clipped_reg <= s3_clip_reg || out_clip;
        end
    end

    assign drive_value   = drive_value_reg;
    assign integral_used = integral_used_reg;
    assign drive_clipped = drive_clipped_reg;

    // The integral changes only when a beat enters the update stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(acc_reg) |-> $past(load1))
    else $error("integral changed without a beat entering the update stage");

    // The input side stalls only while its register holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        measurement_stall |-> v0_reg)
    else $error("input stalled with an empty input register");

    // A new result beat comes only from a filled product stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(v3_reg))
    else $error("result beat appeared without a beat in the product stage");

endmodule

`default_nettype wire

// File: dv/tb_antiwindup_separation_pid.sv
// ============================================================================
// tb_antiwindup_separation_pid
// Self-checking testbench for the separation PID controller.
// ============================================================================
// Measurement beats are pushed through the block in bursts with random gaps
// while the result side stalls on a pattern of its own. A scoreboard class
// keeps a bit-exact model of the controller state and register settings,
// predicts each result beat, and compares every field of every result.
// The run covers reset defaults, a directed set of corner cases, several
// random register settings, and a short run of back-to-back beats with no
// gaps and no stalls.
// ============================================================================

module tb_antiwindup_separation_pid;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
    localparam int unsigned QUIET_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] meas;
        logic signed [31:0] drive;
        logic               used;
        logic               clipped;
    } drive_step_t;

    typedef enum int unsigned {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

    class pid_tracker;
        logic signed [31:0] setpoint = '0;
        logic [23:0]        gain_p = '0;
        logic [23:0]        gain_i = '0;
        logic [23:0]        gain_d = '0;
        logic [30:0]        sep_limit = '0;
        logic signed [31:0] upper = WORD_MAX;
        logic signed [31:0] lower = WORD_MIN;
        logic signed [47:0] accum = '0;
        logic signed [31:0] last_err = '0;
        drive_step_t        pending[$];
        int unsigned        mismatches = 0;

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        function void apply_setting(asp_pkg::asp_reg_t r, logic [31:0] v);
            case (r)
                asp_pkg::REG_SETPOINT:   setpoint = v;
                asp_pkg::REG_GAIN_P:     gain_p = v[asp_pkg::GAIN_WIDTH-1:0];
                asp_pkg::REG_GAIN_I:     gain_i = v[asp_pkg::GAIN_WIDTH-1:0];
                asp_pkg::REG_GAIN_D:     gain_d = v[asp_pkg::GAIN_WIDTH-1:0];
                asp_pkg::REG_SEP_LIMIT:  sep_limit = v[30:0];
                asp_pkg::REG_MEAS_UPPER: upper = v;
                asp_pkg::REG_MEAS_LOWER: lower = v;
                default:                 ;
            endcase
        endfunction

        function void note_measurement(logic signed [31:0] meas);
            logic signed [32:0]  diff;
            logic signed [31:0]  err;
            logic signed [32:0]  e33;
            logic [32:0]         mag;
            logic                add_err;
            logic signed [48:0]  acc_sum;
            logic signed [127:0] total;
            logic signed [127:0] scaled;
            drive_step_t         s;
            s.meas = meas;
            s.clipped = 1'b0;
            diff = 33'(setpoint) - 33'(meas);
            if (diff > WORD_MAX) begin
                err = WORD_MAX;
                s.clipped = 1'b1;
            end
            else if (diff < WORD_MIN) begin
                err = WORD_MIN;
                s.clipped = 1'b1;
            end
            else
                err = diff[31:0];
            e33 = 33'(err);
            mag = (e33 < 0) ? -e33 : e33;
            s.used = (mag <= {2'b00, sep_limit});
            add_err = 1'b0;
            if (s.used) begin
                if (meas > upper)
                    add_err = 1'b0;
                else if (meas < lower)
                    add_err = (err > 0);
                else
                    add_err = 1'b1;
            end
            if (add_err) begin
                acc_sum = 49'(accum) + 49'(err);
                if (acc_sum > ACC_MAX)
                    accum = ACC_MAX;
                else if (acc_sum < ACC_MIN)
                    accum = ACC_MIN;
                else
                    accum = acc_sum[47:0];
            end
            total = 128'(err) * 128'($signed({1'b0, gain_p}));
            total = total + (128'(err) - 128'(last_err)) * 128'($signed({1'b0, gain_d}));
            if (s.used)
                total = total + 128'(accum) * 128'($signed({1'b0, gain_i}));
            scaled = total >>> asp_pkg::FRAC_BITS_DEF;
            if (scaled > WORD_MAX) begin
                s.drive = WORD_MAX;
                s.clipped = 1'b1;
            end
            else if (scaled < WORD_MIN) begin
                s.drive = WORD_MIN;
                s.clipped = 1'b1;
            end
            else
                s.drive = scaled[31:0];
            last_err = err;
            pending.push_back(s);
        endfunction

        task check_result(logic signed [31:0] drive, logic used, logic clipped);
            drive_step_t s;
            if (pending.size() == 0) begin
                report($sformatf("result beat drive_value %0d with nothing pending", drive));
                return;
            end
            s = pending.pop_front();
            if (drive !== s.drive)
                report($sformatf("drive_value %0d, expected %0d (measurement %0d)",
                                 drive, s.drive, s.meas));
            if (used !== s.used)
                report($sformatf("integral_used %0b, expected %0b (measurement %0d)",
                                 used, s.used, s.meas));
            if (clipped !== s.clipped)
                report($sformatf("drive_clipped %0b, expected %0b (measurement %0d)",
                                 clipped, s.clipped, s.meas));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               measurement_valid = 1'b0;
    logic               measurement_stall;
    logic signed [31:0] measurement = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] drive_value;
    logic               integral_used;
    logic               drive_clipped;

    pid_tracker  tracker = new();
    bit          idling_on = 1'b1;
    int unsigned burst_left = 0;
    flow_t       stall_mode = FLOW_FREE;
    int unsigned stall_span = 0;

    antiwindup_separation_pid DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .measurement_valid (measurement_valid),
        .measurement_stall (measurement_stall),
        .measurement       (measurement),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .drive_value       (drive_value),
        .integral_used     (integral_used),
        .drive_clipped     (drive_clipped)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(drive_value, integral_used, drive_clipped);
        if (stall_span == 0)
        begin
            stall_mode = flow_t'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 200);
        end
        stall_span--;
        if (!idling_on)
            result_stall <= 1'b0;
        else
        begin
            case (stall_mode)
                FLOW_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
                FLOW_PERIODIC: result_stall <= ((stall_span % 8) < 3);
                default:       result_stall <= 1'b0;
            endcase
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((measurement_valid && !measurement_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // The select stays high between back-to-back writes; the caller drops it.
    task automatic apb_write(asp_pkg::asp_reg_t r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.apply_setting(r, v);
    endtask

    task automatic load_settings(logic signed [31:0] sp, logic [23:0] gp, logic [23:0] gi,
                                 logic [23:0] gd, logic [30:0] sep,
                                 logic signed [31:0] up, logic signed [31:0] lo);
        apb_write(asp_pkg::REG_SETPOINT, sp);
        apb_write(asp_pkg::REG_GAIN_P, {8'b0, gp});
        apb_write(asp_pkg::REG_GAIN_I, {8'b0, gi});
        apb_write(asp_pkg::REG_GAIN_D, {8'b0, gd});
        apb_write(asp_pkg::REG_SEP_LIMIT, {1'b0, sep});
        apb_write(asp_pkg::REG_MEAS_UPPER, up);
        apb_write(asp_pkg::REG_MEAS_LOWER, lo);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_measurement(logic signed [31:0] m);
        int unsigned gap;
        if (idling_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                measurement_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        measurement_valid <= 1'b1;
        measurement <= m;
        do @(posedge clk); while (measurement_stall);
        tracker.note_measurement(m);
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic settle();
        measurement_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [31:0] random_measurement();
        logic signed [31:0] offset;
        logic signed [31:0] corner_vals[4];
        corner_vals = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1};
        offset = $signed($urandom) >>> $urandom_range(0, 28);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return corner_vals[$urandom_range(0, 3)];
            3:       return tracker.upper + ($signed($urandom) >>> 29);
            4:       return tracker.lower + ($signed($urandom) >>> 29);
            default: return tracker.setpoint - offset;
        endcase
    endfunction

    task automatic random_settings();
        logic signed [31:0] sp;
        logic signed [31:0] up;
        logic signed [31:0] lo;
        logic signed [31:0] swap;
        logic [23:0]        g[3];
        logic [30:0]        sep;
        int                 k;
        case ($urandom_range(0, 5))
            0:       sp = WORD_MAX;
            1:       sp = WORD_MIN;
            2:       sp = $urandom;
            default: sp = $signed($urandom) >>> 8;
        endcase
        for (k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 5))
                0:       g[k] = '0;
                1:       g[k] = 24'hFF_FFFF;
                2:       g[k] = 24'($urandom);
                default: g[k] = 24'($urandom_range(0, 24'h02_0000));
            endcase
        end
        case ($urandom_range(0, 4))
            0:       sep = '0;
            1:       sep = 31'h7FFF_FFFF;
            2:       sep = 31'($urandom);
            default: sep = 31'($urandom_range(0, 32'h0040_0000));
        endcase
        up = sp + ($signed($urandom) >>> $urandom_range(6, 30));
        lo = sp + ($signed($urandom) >>> $urandom_range(6, 30));
        case ($urandom_range(0, 5))
            0:
            begin
                up = WORD_MAX;
                lo = WORD_MIN;
            end
            1:
            begin
                up = WORD_MIN;
                lo = WORD_MAX;
            end
            2:       ;
            default:
            begin
                if (up < lo)
                begin
                    swap = up;
                    up = lo;
                    lo = swap;
                end
            end
        endcase
        load_settings(sp, g[0], g[1], g[2], sep, up, lo);
    endtask

    initial
    begin : stimulus
        int phase;
        @(posedge rst_n);
        @(posedge clk);

        send_measurement(32'sd0);
        send_measurement(WORD_MIN);
        send_measurement(WORD_MAX);

        settle();
        load_settings(32'sd0, 24'h01_0000, 24'h00_0100, 24'h00_8000, 31'h0010_0000,
                      32'sh0008_0000, -32'sh0008_0000);
        send_measurement(32'sd0);
        send_measurement(32'sh0001_0000);
        send_measurement(-32'sh0001_0000);
        send_measurement(32'sh0010_0000);
        send_measurement(32'sh0010_0001);
        send_measurement(-32'sh0010_0000);

        settle();
        load_settings(WORD_MAX, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF,
                      WORD_MAX, WORD_MIN);
        send_measurement(WORD_MIN);
        send_measurement(WORD_MAX);
        send_measurement(-32'sd1);

        settle();
        load_settings(WORD_MIN, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF,
                      WORD_MAX, WORD_MIN);
        send_measurement(32'sd1);
        send_measurement(WORD_MAX);
        send_measurement(WORD_MIN);

        settle();
        load_settings(32'sh50, 24'h01_0000, 24'h00_1000, 24'h00_0000, 31'h7FFF_FFFF,
                      -32'sh100, 32'sh100);
        send_measurement(32'sh200);
        send_measurement(-32'sh200);
        send_measurement(32'sd0);
        send_measurement(32'sh50);

        settle();
        load_settings(-32'sh1000, 24'h01_0000, 24'h01_0000, 24'h00_0400, 31'h0001_0000,
                      WORD_MAX, 32'sd0);
        send_measurement(-32'sh10);
        send_measurement(-32'sh1000);
        send_measurement(-32'sh2000);
        send_measurement(32'sh10);

        for (phase = 0; phase < 6; phase++)
        begin
            settle();
            random_settings();
            repeat ($urandom_range(100, 140))
                send_measurement(random_measurement());
        end

        // Back-to-back beats with the largest error, no gaps and no stalls.
        settle();
        idling_on = 1'b0;
        load_settings(WORD_MAX, 24'h00_0100, 24'h00_0001, 24'h00_0010, 31'h7FFF_FFFF,
                      WORD_MAX, WORD_MIN);
        repeat (60)
            send_measurement(32'sd0);

        settle();
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
